/* hw/rtl/tcw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Shared widths, limits and command codes of the character-cell console.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int MAX_COLUMNS = 80;
   localparam int MAX_ROWS    = 25;
   localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;

   localparam int CMD_W   = 3;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CELL_W  = 16;
   localparam int ADDR_W  = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SETCUR = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SCRUP  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SCRDN  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_COLUMNS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS    = 1'd1;

   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

endpackage : tcw_pkg
`default_nettype wire

/* hw/rtl/text_console_writer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer core
// Character-cell console with a 2000-cell store, a cursor and a sequencer
// that walks the store for clear and scroll commands.
// ----------------------------------------------------------------------------
// Clear and scroll walk all columns*rows cells through the single-port store:
//   a blanked cell takes one write, a copied cell a read and a write; a put
//   that wraps or starts a new line on the last row adds such a walk.
// Throughput: one command at a time; busy stays high until the result strobe.
// Reset (synchronous): cursor to 0,0, columns 80, rows 25, sequencer idle.
//   The store keeps whatever it holds; it is defined once cleared or written.
// The receiver cannot stall: every result is shown for one cycle only.

module text_console_writer_core (
   input  wire                              clock,
   input  wire                              reset,
   // command channel
   input  wire                              start,
   output logic                             busy,
   input  wire  [tcw_pkg::CMD_W-1:0]        req_cmd,
   input  wire  [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input  wire  [tcw_pkg::ATTR_W-1:0]       req_attribute,
   input  wire  [tcw_pkg::COL_W-1:0]        req_col,
   input  wire  [tcw_pkg::ROW_W-1:0]        req_row,
   input  wire  [tcw_pkg::ROW_W-1:0]        req_count,
   // result channel
   output logic                             rsp_valid,
   output logic [tcw_pkg::CELL_W-1:0]       rsp_cell_data,
   output logic [tcw_pkg::COL_W-1:0]        rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]        rsp_cursor_row,
   output logic [tcw_pkg::ADDR_W-1:0]       rsp_cursor_location,
   // register write channel
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [tcw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [tcw_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tcw_pkg::*;

   // Sequencer codes.
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE     = 4'd0;
   localparam logic [ST_W-1:0] S_DISPATCH = 4'd1;
   localparam logic [ST_W-1:0] S_PUT_ADDR = 4'd2;
   localparam logic [ST_W-1:0] S_PUT_WR   = 4'd3;
   localparam logic [ST_W-1:0] S_RC_ADDR  = 4'd4;
   localparam logic [ST_W-1:0] S_RC_RD    = 4'd5;
   localparam logic [ST_W-1:0] S_RC_WR    = 4'd6;
   localparam logic [ST_W-1:0] S_RD_ADDR  = 4'd7;
   localparam logic [ST_W-1:0] S_RD_RD    = 4'd8;
   localparam logic [ST_W-1:0] S_RD_DATA  = 4'd9;
   localparam logic [ST_W-1:0] S_WK_SH    = 4'd10;
   localparam logic [ST_W-1:0] S_WK_TOT   = 4'd11;
   localparam logic [ST_W-1:0] S_WK_INIT  = 4'd12;
   localparam logic [ST_W-1:0] S_WK_RD    = 4'd13;
   localparam logic [ST_W-1:0] S_WK_WR    = 4'd14;
   localparam logic [ST_W-1:0] S_FINISH   = 4'd15;

   localparam logic [COL_W-1:0] MAX_COL_V = COL_W'(MAX_COLUMNS);
   localparam logic [ROW_W-1:0] MAX_ROW_V = ROW_W'(MAX_ROWS);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [ST_W-1:0]    state_ff, state_in;
   logic [COL_W-1:0]   columns_ff, columns_in;
   logic [ROW_W-1:0]   rows_ff, rows_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;

   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [ATTR_W-1:0]  attr_ff, attr_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ROW_W-1:0]   count_ff, count_in;

   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [CELL_W-1:0]  data_ff, data_in;

   // Walk engine: direction, row count, cell offset, cell total, position, end.
   logic               wk_up_ff, wk_up_in;
   logic [ROW_W-1:0]   wk_n_ff, wk_n_in;
   logic [ADDR_W-1:0]  wk_sh_ff, wk_sh_in;
   logic [ADDR_W-1:0]  wk_tot_ff, wk_tot_in;
   logic [ADDR_W-1:0]  wk_idx_ff, wk_idx_in;
   logic [ADDR_W-1:0]  wk_end_ff, wk_end_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [ADDR_W-1:0]  rsp_loc_ff, rsp_loc_in;

   // Cell store, single port with registered read data.
   logic [CELL_W-1:0]  mem [0:CELLS-1];
   logic [CELL_W-1:0]  rdata_ff;
   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_addr;
   logic [CELL_W-1:0]  mem_wdata;

   // ------------------------------------------------------------------
   // Effective geometry: a zero register counts as one, an oversized one
   // is held at the store's limit.
   // ------------------------------------------------------------------
   logic [COL_W-1:0]   nc;
   logic [ROW_W-1:0]   nr;
   logic [ROW_W-1:0]   last_row;

   always_comb begin
      if (columns_ff == '0) begin
         nc = COL_W'(1);
      end else if (columns_ff > MAX_COL_V) begin
         nc = MAX_COL_V;
      end else begin
         nc = columns_ff;
      end
      if (rows_ff == '0) begin
         nr = ROW_W'(1);
      end else if (rows_ff > MAX_ROW_V) begin
         nr = MAX_ROW_V;
      end else begin
         nr = rows_ff;
      end
      last_row = nr - ROW_W'(1);
   end

   // ------------------------------------------------------------------
   // Shared multiplier: columns times a row number chosen by the state.
   // It serves the cursor address, the read address, the scroll offset and
   // the screen size in turn.
   // ------------------------------------------------------------------
   logic [ROW_W-1:0]        mul_b;
   logic [COL_W+ROW_W-1:0]  mul_full;
   logic [ADDR_W-1:0]       mul_p;

   always_comb begin
      case (state_ff)
         S_RD_ADDR: begin
            mul_b = row_ff;
         end
         S_WK_SH: begin
            mul_b = wk_n_ff;
         end
         S_WK_TOT: begin
            mul_b = nr;
         end
         default: begin
            mul_b = cur_row_ff;
         end
      endcase
      mul_full = (COL_W+ROW_W)'(nc) * (COL_W+ROW_W)'(mul_b);
      mul_p    = mul_full[ADDR_W-1:0];
   end

   // Walk address arithmetic.
   logic [ADDR_W:0]    src_up;
   logic [ADDR_W-1:0]  src;
   logic               wk_copy;
   logic               wk_last;
   logic [ST_W-1:0]    wk_done_state;

   always_comb begin
      src_up = {1'b0, wk_idx_ff} + {1'b0, wk_sh_ff};
      if (wk_up_ff) begin
         wk_copy = src_up < {1'b0, wk_tot_ff};
         src     = src_up[ADDR_W-1:0];
      end else begin
         wk_copy = wk_idx_ff >= wk_sh_ff;
         src     = wk_idx_ff - wk_sh_ff;
      end
      wk_last = (wk_idx_ff == wk_end_ff);
      // A put that scrolled goes on to write its character or recolour.
      if (cmd_ff == CMD_PUT) begin
         wk_done_state = (char_ff == NEWLINE_CHAR) ? S_RC_ADDR : S_PUT_ADDR;
      end else begin
         wk_done_state = S_FINISH;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   logic [ROW_W-1:0]  scroll_n;

   always_comb begin
      state_in     = state_ff;
      columns_in   = columns_ff;
      rows_in      = rows_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      cmd_in       = cmd_ff;
      char_in      = char_ff;
      attr_in      = attr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      wk_up_in     = wk_up_ff;
      wk_n_in      = wk_n_ff;
      wk_sh_in     = wk_sh_ff;
      wk_tot_in    = wk_tot_ff;
      wk_idx_in    = wk_idx_ff;
      wk_end_in    = wk_end_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_loc_in   = rsp_loc_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = addr_ff;
      mem_wdata    = {attr_ff, char_ff};
      scroll_n     = (count_ff > nr) ? nr : count_ff;

      // Register beats are only to be sent while the block is idle; the block does not enforce it.
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_COLUMNS: begin
               columns_in = csr_wdata[COL_W-1:0];
            end
            REG_ROWS: begin
               rows_in = csr_wdata[ROW_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_cmd;
               char_in  = req_char_code;
               attr_in  = req_attribute;
               col_in   = req_col;
               row_in   = req_row;
               count_in = req_count;
               data_in  = '0;
               // The cursor is pulled back inside the screen before use.
               if (cur_col_ff > nc) begin
                  cur_col_in = nc;
               end
               if (cur_row_ff > last_row) begin
                  cur_row_in = last_row;
               end
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            case (cmd_ff)
               CMD_PUT: begin
                  if ((char_ff == NEWLINE_CHAR) || (cur_col_ff >= nc)) begin
                     cur_col_in = '0;
                     if (cur_row_ff >= last_row) begin
                        wk_up_in = 1'b1;
                        wk_n_in  = ROW_W'(1);
                        state_in = S_WK_SH;
                     end else begin
                        cur_row_in = cur_row_ff + ROW_W'(1);
                        state_in   = (char_ff == NEWLINE_CHAR) ? S_RC_ADDR : S_PUT_ADDR;
                     end
                  end else begin
                     state_in = S_PUT_ADDR;
                  end
               end
               CMD_SETCUR: begin
                  cur_col_in = (col_ff > nc) ? nc : col_ff;
                  cur_row_in = (row_ff > last_row) ? last_row : row_ff;
                  state_in   = S_RC_ADDR;
               end
               CMD_CLEAR: begin
                  // Blanking every cell leaves cell 0 already recoloured.
                  cur_col_in = '0;
                  cur_row_in = '0;
                  wk_up_in   = 1'b1;
                  wk_n_in    = nr;
                  state_in   = S_WK_SH;
               end
               CMD_SCRUP, CMD_SCRDN: begin
                  wk_up_in = (cmd_ff == CMD_SCRUP);
                  wk_n_in  = scroll_n;
                  state_in = (scroll_n == '0) ? S_FINISH : S_WK_SH;
               end
               CMD_READ: begin
                  state_in = ((col_ff < nc) && (row_ff < nr)) ? S_RD_ADDR : S_FINISH;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end

         S_PUT_ADDR: begin
            addr_in  = ADDR_W'(cur_col_ff) + mul_p;
            state_in = S_PUT_WR;
         end

         S_PUT_WR: begin
            mem_we     = 1'b1;
            mem_wdata  = {attr_ff, char_ff};
            cur_col_in = cur_col_ff + COL_W'(1);
            state_in   = S_RC_ADDR;
         end

         S_RC_ADDR: begin
            addr_in = ADDR_W'(cur_col_ff) + mul_p;
            // Only on the last row does the pending-wrap spot fall past the screen's cells.
            if ((cur_row_ff == last_row) && (cur_col_ff == nc)) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_RC_RD;
            end
         end

         S_RC_RD: begin
            mem_re   = 1'b1;
            state_in = S_RC_WR;
         end

         S_RC_WR: begin
            mem_we    = 1'b1;
            mem_wdata = {attr_ff, rdata_ff[CHAR_W-1:0]};
            state_in  = S_FINISH;
         end

         S_RD_ADDR: begin
            addr_in  = ADDR_W'(col_ff) + mul_p;
            state_in = S_RD_RD;
         end

         S_RD_RD: begin
            mem_re   = 1'b1;
            state_in = S_RD_DATA;
         end

         S_RD_DATA: begin
            data_in  = rdata_ff;
            state_in = S_FINISH;
         end

         S_WK_SH: begin
            wk_sh_in = mul_p;
            state_in = S_WK_TOT;
         end

         S_WK_TOT: begin
            wk_tot_in = mul_p;
            state_in  = S_WK_INIT;
         end

         S_WK_INIT: begin
            // Upward walks run low to high, downward ones high to low, so a
            // source cell is always read before it is overwritten.
            if (wk_up_ff) begin
               wk_idx_in = '0;
               wk_end_in = wk_tot_ff - ADDR_W'(1);
            end else begin
               wk_idx_in = wk_tot_ff - ADDR_W'(1);
               wk_end_in = '0;
            end
            state_in = S_WK_RD;
         end

         S_WK_RD: begin
            if (wk_copy) begin
               mem_re   = 1'b1;
               mem_addr = src;
               state_in = S_WK_WR;
            end else begin
               mem_we    = 1'b1;
               mem_addr  = wk_idx_ff;
               mem_wdata = {attr_ff, BLANK_CHAR};
               if (wk_last) begin
                  state_in = wk_done_state;
               end else begin
                  wk_idx_in = wk_up_ff ? wk_idx_ff + ADDR_W'(1) : wk_idx_ff - ADDR_W'(1);
               end
            end
         end

         S_WK_WR: begin
            mem_we    = 1'b1;
            mem_addr  = wk_idx_ff;
            mem_wdata = rdata_ff;
            if (wk_last) begin
               state_in = wk_done_state;
            end else begin
               wk_idx_in = wk_up_ff ? wk_idx_ff + ADDR_W'(1) : wk_idx_ff - ADDR_W'(1);
               state_in  = S_WK_RD;
            end
         end

         S_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = data_ff;
            rsp_col_in   = cur_col_ff;
            rsp_row_in   = cur_row_ff;
            rsp_loc_in   = ADDR_W'(cur_col_ff) + mul_p;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         columns_ff   <= MAX_COL_V;
         rows_ff      <= MAX_ROW_V;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         columns_ff   <= columns_in;
         rows_ff      <= rows_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      char_ff     <= char_in;
      attr_ff     <= attr_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      count_ff    <= count_in;
      addr_ff     <= addr_in;
      data_ff     <= data_in;
      wk_up_ff    <= wk_up_in;
      wk_n_ff     <= wk_n_in;
      wk_sh_ff    <= wk_sh_in;
      wk_tot_ff   <= wk_tot_in;
      wk_idx_ff   <= wk_idx_in;
      wk_end_ff   <= wk_end_in;
      rsp_data_ff <= rsp_data_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_loc_ff  <= rsp_loc_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   assign busy                = (state_ff != S_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_data       = rsp_data_ff;
   assign rsp_cursor_col      = rsp_col_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_cursor_location = rsp_loc_ff;

endmodule : text_console_writer_core
`default_nettype wire

/* hw/rtl/tcw_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level properties of the command and result beats, bound to the core.
// ----------------------------------------------------------------------------
module tcw_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           start,
   input wire                           busy,
   input wire                           rsp_valid,
   input wire [tcw_pkg::COL_W-1:0]      rsp_cursor_col,
   input wire [tcw_pkg::ROW_W-1:0]      rsp_cursor_row
);
   import tcw_pkg::*;

   // An accepted command beat makes the core busy.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command beat accepted without going busy");

   // Every command ends in exactly one result beat.
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      (!busy && $past(busy) && !$past(reset)) |-> rsp_valid)
      else $error("command finished without a result beat");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result beat outside the end of a command");

   // The reported cursor stays within the largest screen or its pending-wrap spot.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_cursor_col <= COL_W'(MAX_COLUMNS)) &&
                     (rsp_cursor_row < ROW_W'(MAX_ROWS))))
      else $error("reported cursor outside the screen");

endmodule : tcw_checker

bind text_console_writer_core tcw_checker u_tcw_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_cursor_col (rsp_cursor_col),
   .rsp_cursor_row (rsp_cursor_row)
);
`default_nettype wire
